@@ sv/assert_macros.svh @@
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion that is switched off while reset is asserted.
`define CPDF_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Clocked assertion that also holds across reset.
`define CPDF_ASSERT_ALWAYS(label, clk, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);

`endif

@@ sv/cpdf_pkg.sv @@
`timescale 1ns / 1ps

package cpdf_pkg;

    localparam int FRAME_BYTES_DEF = 256;
    localparam int ADDR_W = 7;
    localparam logic [ADDR_W-1:0] TARGET_ADDRESS_RST = 7'd60;
    localparam logic [7:0] CTRL_DATA = 8'h40;
    localparam int K_W = 5;
    localparam logic [K_W-1:0] K_LAST = 5'd16;

    typedef enum logic [0:0] {
        ST_COLLECT,
        ST_EMIT
    } t_state;

    typedef struct packed {
        logic accept;
        logic emit;
    } t_cmd;

    typedef struct packed {
        logic col_full;
        logic emit_last;
        logic out_free;
    } t_status;

    function automatic logic [7:0] nib_double(input logic [3:0] nib);
        logic [7:0] res;
        res = '0;
        for (int i = 0; i < 4; i++) begin
            res[2*i]   = nib[i];
            res[2*i+1] = nib[i];
        end
        return res;
    endfunction

endpackage

@@ sv/cpdf_ctrl.sv @@
`timescale 1ns / 1ps

module cpdf_ctrl (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_stall,
    input  cpdf_pkg::t_status  i_status,
    output cpdf_pkg::t_cmd     o_cmd
);

    cpdf_pkg::t_state r_state;
    cpdf_pkg::t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= cpdf_pkg::ST_COLLECT;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state      = r_state;
        o_stall      = 1'b1;
        o_cmd.accept = 1'b0;
        o_cmd.emit   = 1'b0;
        case (r_state)
            cpdf_pkg::ST_COLLECT: begin
                o_stall      = 1'b0;
                o_cmd.accept = i_valid;
                if (i_valid && i_status.col_full) begin
                    n_state = cpdf_pkg::ST_EMIT;
                end
            end
            cpdf_pkg::ST_EMIT: begin
                o_cmd.emit = i_status.out_free;
                if (i_status.out_free && i_status.emit_last) begin
                    n_state = cpdf_pkg::ST_COLLECT;
                end
            end
            default: begin
                n_state = cpdf_pkg::ST_COLLECT;
            end
        endcase
    end

endmodule

@@ sv/cpdf_dp.sv @@
`timescale 1ns / 1ps

module cpdf_dp #(
    parameter int FRAME_BYTES = cpdf_pkg::FRAME_BYTES_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  cpdf_pkg::t_cmd                i_cmd,
    output cpdf_pkg::t_status             o_status,
    input  logic [7:0]                    i_pixel_byte,
    input  logic                          i_stall,
    input  logic                          i_cfg_valid,
    input  logic [cpdf_pkg::ADDR_W-1:0]   i_cfg_data,
    output logic                          o_valid,
    output logic [7:0]                    o_data_byte,
    output logic                          o_start_of_transaction,
    output logic                          o_end_of_transaction,
    output logic                          o_end_of_frame,
    output logic [cpdf_pkg::ADDR_W-1:0]   o_bus_address
);

    localparam int COLS_RAW = FRAME_BYTES / 4;
    localparam int NUM_COLS = (COLS_RAW < 1) ? 1 : COLS_RAW;
    localparam int COL_W = (NUM_COLS > 1) ? $clog2(NUM_COLS) : 1;
    localparam logic [COL_W-1:0] LAST_COL = COL_W'(NUM_COLS - 1);

    logic [7:0]                  r_store [4];
    logic [1:0]                  r_byte_idx;
    logic [COL_W-1:0]            r_col_idx;
    logic [cpdf_pkg::K_W-1:0]    r_k;
    logic [cpdf_pkg::ADDR_W-1:0] r_addr;
    logic                        r_valid;
    logic [7:0]                  r_data;
    logic                        r_sot;
    logic                        r_eot;
    logic                        r_eof;
    logic [cpdf_pkg::ADDR_W-1:0] r_bus_addr;

    logic [cpdf_pkg::K_W-1:0]    w_j;
    logic [7:0]                  w_cur;
    logic [3:0]                  w_nib;
    logic                        w_first;
    logic                        w_last;
    logic                        w_last_col;

    assign w_j        = r_k - cpdf_pkg::K_W'(1);
    assign w_cur      = r_store[w_j[2:1]];
    assign w_nib      = w_j[0] ? w_cur[7:4] : w_cur[3:0];
    assign w_first    = (r_k == '0);
    assign w_last     = (r_k == cpdf_pkg::K_LAST);
    assign w_last_col = (r_col_idx == LAST_COL);

    assign o_status.col_full  = (r_byte_idx == 2'd3);
    assign o_status.emit_last = w_last;
    assign o_status.out_free  = !r_valid || !i_stall;

    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_store[r_byte_idx] <= i_pixel_byte;
        end
        if (i_cmd.emit) begin
            r_data     <= w_first ? cpdf_pkg::CTRL_DATA : cpdf_pkg::nib_double(w_nib);
            r_sot      <= w_first;
            r_eot      <= w_last;
            r_eof      <= w_last && w_last_col;
            r_bus_addr <= r_addr;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_byte_idx <= '0;
            r_col_idx  <= '0;
            r_k        <= '0;
            r_addr     <= cpdf_pkg::TARGET_ADDRESS_RST;
            r_valid    <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                r_addr <= i_cfg_data;
            end
            if (i_cmd.accept) begin
                r_byte_idx <= r_byte_idx + 2'd1;
                if (r_byte_idx == 2'd3) begin
                    r_k <= '0;
                end
            end else if (i_cmd.emit) begin
                r_k <= r_k + cpdf_pkg::K_W'(1);
                if (w_last) begin
                    r_col_idx <= w_last_col ? '0 : r_col_idx + COL_W'(1);
                end
            end
            if (i_cmd.emit) begin
                r_valid <= 1'b1;
            end else if (!i_stall) begin
                r_valid <= 1'b0;
            end
        end
    end

    assign o_valid                = r_valid;
    assign o_data_byte            = r_data;
    assign o_start_of_transaction = r_sot;
    assign o_end_of_transaction   = r_eot;
    assign o_end_of_frame         = r_eof;
    assign o_bus_address          = r_bus_addr;

endmodule

@@ sv/column_pixel_doubler_framer_core.sv @@
// The fourth byte moves control to ST_EMIT; the control byte is registered on out_free.
// Throughput: a column gives 17 bytes at one per unstalled cycle; input is stalled meanwhile.
// Unstalled, the input rate is set by the emitter.
// Reset is synchronous and active low: counters clear, target address returns to 60.
// The column store is not cleared; a column is sent only after all four bytes arrive.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module column_pixel_doubler_framer_core #(
    parameter int FRAME_BYTES = cpdf_pkg::FRAME_BYTES_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    output logic                          o_stall,
    input  logic [7:0]                    i_pixel_byte,
    output logic                          o_valid,
    input  logic                          i_stall,
    output logic [7:0]                    o_data_byte,
    output logic                          o_start_of_transaction,
    output logic                          o_end_of_transaction,
    output logic                          o_end_of_frame,
    output logic [cpdf_pkg::ADDR_W-1:0]   o_bus_address,
    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  logic [cpdf_pkg::ADDR_W-1:0]   i_cfg_data
);

    cpdf_pkg::t_cmd    w_cmd;
    cpdf_pkg::t_status w_status;

    assign o_cfg_ready = 1'b1;

    cpdf_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (i_valid),
        .o_stall  (o_stall),
        .i_status (w_status),
        .o_cmd    (w_cmd)
    );

    cpdf_dp #(
        .FRAME_BYTES (FRAME_BYTES)
    ) u_dp (
        .i_clk                  (i_clk),
        .i_rst_n                (i_rst_n),
        .i_cmd                  (w_cmd),
        .o_status               (w_status),
        .i_pixel_byte           (i_pixel_byte),
        .i_stall                (i_stall),
        .i_cfg_valid            (i_cfg_valid),
        .i_cfg_data             (i_cfg_data),
        .o_valid                (o_valid),
        .o_data_byte            (o_data_byte),
        .o_start_of_transaction (o_start_of_transaction),
        .o_end_of_transaction   (o_end_of_transaction),
        .o_end_of_frame         (o_end_of_frame),
        .o_bus_address          (o_bus_address)
    );

    `CPDF_ASSERT(a_sot_eot_excl, i_clk, i_rst_n, o_valid |-> !(o_start_of_transaction && o_end_of_transaction), "start and end of transaction on one byte")
    `CPDF_ASSERT(a_eof_on_eot, i_clk, i_rst_n, (o_valid && o_end_of_frame) |-> o_end_of_transaction, "end of frame away from end of transaction")
    `CPDF_ASSERT(a_sot_ctrl_byte, i_clk, i_rst_n, (o_valid && o_start_of_transaction) |-> (o_data_byte == cpdf_pkg::CTRL_DATA), "transaction start without control byte")
    `CPDF_ASSERT(a_hold_stalled, i_clk, i_rst_n, (o_valid && i_stall) |=> (o_valid && $stable(o_data_byte) && $stable(o_bus_address)), "stalled output byte changed")
    `CPDF_ASSERT_ALWAYS(a_reset_idle, i_clk, !i_rst_n |=> !o_valid, "output valid after reset")

endmodule
